### sv/assert_macros.svh
// assertion macros used by the formatter serialiser rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("formatter assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("formatter forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/sdaf_pkg.sv
// constants and types of the signed decimal ascii formatter
// no dependencies; used by every module of the formatter
`timescale 1ns / 1ps

package sdaf_pkg;

    localparam int VALUE_W       = 64;
    localparam int CHAR_W        = 7;
    localparam int DIGITS        = 19;              // 2**63 has 19 decimal digits
    localparam int BCD_W         = 4 * DIGITS;
    localparam int CNT_W         = $clog2(DIGITS + 1);
    localparam int DABBLE_STEPS  = 8;               // bits converted per stage
    localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    // payload of one conversion stage
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
    } dabble_t;

    // converted number handed to the serialiser
    typedef struct packed {
        logic             neg;
        logic [CNT_W-1:0] ndig;
        logic [BCD_W-1:0] bcd;
    } item_t;

endpackage

### sv/sdaf_dabble_stage.sv
// one stage of the binary to bcd shift-and-add-3 pipeline
// depends on sdaf_pkg
`timescale 1ns / 1ps

module sdaf_dabble_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sdaf_pkg::dabble_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sdaf_pkg::dabble_t out_data
);
    import sdaf_pkg::*;

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    // several binary bits shifted into the bcd word
    always_comb begin
        logic [BCD_W-1:0]   t;
        logic [VALUE_W-1:0] b;
        t = in_data.bcd;
        b = in_data.bin;
        for (int s = 0; s < DABBLE_STEPS; s++) begin
            for (int k = 0; k < DIGITS; k++) begin
                if (t[k*4 +: 4] >= 4'd5) begin
                    t[k*4 +: 4] = t[k*4 +: 4] + 4'd3;
                end
            end
            t = {t[BCD_W-2:0], b[VALUE_W-1]};
            b = {b[VALUE_W-2:0], 1'b0};
        end
        data_next.neg = in_data.neg;
        data_next.bin = b;
        data_next.bcd = t;
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register with valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/sdaf_serialiser.sv
// turns one converted number into a run of ascii characters
// depends on sdaf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdaf_serialiser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  sdaf_pkg::item_t               item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sdaf_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last
);
    import sdaf_pkg::*;

    logic             ser_valid_reg, ser_valid_next;
    logic             ser_neg_reg, ser_neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;

    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic              m_last_reg;

    logic              out_load;
    logic              emit;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W+1:0]  bit_pos;
    logic [CHAR_W-1:0] cur_char;
    logic              cur_last;

    // character at the head of the current run
    always_comb begin
        idx     = cnt_reg - CNT_W'(1);
        bit_pos = {idx, 2'b00};
        if (ser_neg_reg) begin
            cur_char = CHAR_MINUS;
            cur_last = 1'b0;
        end else begin
            cur_char = CHAR_ZERO + CHAR_W'(bcd_reg[bit_pos +: 4]);
            cur_last = (cnt_reg == CNT_W'(1));
        end
    end

    assign out_load   = !m_valid_reg || out_ready;
    assign emit       = ser_valid_reg && out_load;
    assign item_ready = !ser_valid_reg || (emit && cur_last);

    // run state: advance on emit, reload when the run ends
    always_comb begin
        ser_valid_next = ser_valid_reg;
        ser_neg_next   = ser_neg_reg;
        cnt_next       = cnt_reg;
        bcd_next       = bcd_reg;
        if (emit) begin
            if (ser_neg_reg) begin
                ser_neg_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            if (cur_last) begin
                ser_valid_next = 1'b0;
            end
        end
        if (item_valid && item_ready) begin
            ser_valid_next = 1'b1;
            ser_neg_next   = item.neg;
            cnt_next       = item.ndig;
            bcd_next       = item.bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_neg_reg   <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            ser_neg_reg   <= ser_neg_next;
            cnt_reg       <= cnt_next;
            if (out_load) begin
                m_valid_reg <= ser_valid_reg;
            end
        end
        bcd_reg <= bcd_next;
        if (out_load) begin
            m_char_reg <= cur_char;
            m_last_reg <= cur_last;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_char  = m_char_reg;
    assign out_last  = m_last_reg;

    `ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, ser_valid_reg |-> (cnt_reg != '0 && cnt_reg <= CNT_W'(DIGITS)))
    `ASSERT_ALWAYS(a_load_ndig, aclk, aresetn, (item_valid && item_ready) |-> (item.ndig != '0 && item.ndig <= CNT_W'(DIGITS)))
    `ASSERT_NEVER(a_last_minus, aclk, aresetn, m_valid_reg && m_last_reg && (m_char_reg == CHAR_MINUS))
    `ASSERT_ALWAYS(a_minus_then_digit, aclk, aresetn, (emit && ser_neg_reg) |=> (ser_valid_reg && !ser_neg_reg))

endmodule

### sv/signed_decimal_ascii_formatter.sv
// top level of the signed decimal ascii formatter
// depends on sdaf_pkg, sdaf_dabble_stage and sdaf_serialiser
`timescale 1ns / 1ps

// Prints each signed 64-bit input as decimal ASCII text, one character per
// output request: an optional minus sign, then the digits from most to least
// significant without leading zeros, with tlast on the final character (zero
// prints as a single 0; the most negative value prints -9223372036854775808).
// A number passes a magnitude register, eight conversion stages of eight
// bits each, a digit count stage and the serialiser run and output registers
// before its first character is offered. Inputs enter the pipeline every
// cycle while m_tready does not hold it back; sustained throughput is one
// output character per cycle, so a number holds the output channel for its
// text length of 1 to 20 characters. There is no clearing pass after reset.
module signed_decimal_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero fill
    output logic        m_tlast
);
    import sdaf_pkg::*;

    dabble_t st_data  [DABBLE_STAGES+1];
    logic    st_valid [DABBLE_STAGES+1];
    logic    st_ready [DABBLE_STAGES+1];

    logic    mag_valid_reg;
    dabble_t mag_reg;
    dabble_t mag_next;

    logic             cnt_valid_reg;
    logic             cnt_ready;
    item_t            item_reg;
    item_t            item_next;
    logic             ser_ready;

    logic [CHAR_W-1:0] out_char;

    // magnitude of the input value
    always_comb begin
        mag_next.neg = s_tdata[VALUE_W-1];
        mag_next.bin = s_tdata[VALUE_W-1] ? (~s_tdata + VALUE_W'(1)) : s_tdata;
        mag_next.bcd = '0;
    end

    assign s_tready = !mag_valid_reg || st_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_valid_reg <= 1'b0;
        end else if (s_tready) begin
            mag_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            mag_reg <= mag_next;
        end
    end

    assign st_valid[0] = mag_valid_reg;
    assign st_data[0]  = mag_reg;

    // binary to bcd conversion pipeline
    for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
        sdaf_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    // significant digit count, at least one
    always_comb begin
        item_next.neg  = st_data[DABBLE_STAGES].neg;
        item_next.bcd  = st_data[DABBLE_STAGES].bcd;
        item_next.ndig = CNT_W'(1);
        for (int k = 1; k < DIGITS; k++) begin
            if (st_data[DABBLE_STAGES].bcd[k*4 +: 4] != 4'd0) begin
                item_next.ndig = CNT_W'(k + 1);
            end
        end
    end

    assign cnt_ready                = !cnt_valid_reg || ser_ready;
    assign st_ready[DABBLE_STAGES]  = cnt_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_valid_reg <= 1'b0;
        end else if (cnt_ready) begin
            cnt_valid_reg <= st_valid[DABBLE_STAGES];
        end
        if (cnt_ready && st_valid[DABBLE_STAGES]) begin
            item_reg <= item_next;
        end
    end

    // character serialiser with output register
    sdaf_serialiser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (cnt_valid_reg),
        .item_ready (ser_ready),
        .item       (item_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
